// ===== hw/rtl/sgi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared widths, payload types and job format of the 2D segment intersection
// core.
// ----------------------------------------------------------------------------
package sgi_pkg;

  // coordinate and fraction widths
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_T_BITS = 16;

  // derived datapath widths
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = SUM_W;
  localparam int QUOT_W = FRAC_T_BITS + 1;

  // queue between front and back
  localparam int MIDQ_DEPTH = 4;
  localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
  localparam int MIDQ_CW    = MIDQ_AW + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [MAG_W-1:0]              mag_t;
  typedef logic [QUOT_W-1:0]             quot_t;

  // input beat
  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_in_t;

  // result beat
  typedef struct packed {
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
  } seg_out_t;

  // classified job handed from front to back
  typedef struct packed {
    logic   hit;
    mag_t   t_mag;
    mag_t   d_mag;
    coord_t ax0;
    coord_t ay0;
    diff_t  dax;
    diff_t  day;
  } seg_job_t;

endpackage

// ===== hw/rtl/segment_intersection_2d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_2d_core
// Intersection point of two 2D segments in signed Q12.4 fixed point.
// ----------------------------------------------------------------------------
// One segment pair is taken per clock while full is low, and one result beat
// comes out per pair, in order. The front forms the three cross products in
// three stages and classifies the pair; the back runs t = t_num / denom
// through a pipelined restoring divider with one quotient bit per stage, which
// sets the latency, then interpolates along segment A. A miss, including
// parallel segments, reports hit low and a zero point. Both sides stall on
// their own through a short job queue between them and a two-entry result
// queue.
module segment_intersection_2d_core import sgi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  seg_in_t  in_item_i,
  output logic     empty,
  input  logic     pop,
  output seg_out_t out_item_o
);

  logic     job_push, job_full, job_empty, job_pop;
  seg_job_t job_in, job_out;

  // front: products and classification
  sgi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  // queue between front and back
  sgi_midq u_midq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .empty_o (job_empty),
    .pop_i   (job_pop),
    .data_o  (job_out)
  );

  // back: division, interpolation, result queue
  sgi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (out_item_o)
  );

  // a miss always shows a zero point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_item_o.hit |-> out_item_o.cross_x == '0 && out_item_o.cross_y == '0)
    else $error("segment_intersection_2d_core: nonzero point on a miss");

endmodule

// ===== hw/rtl/sgi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_front
// Three-stage front: edge vectors, cross products, then denominator and
// numerators; classifies each pair as hit or miss on the way into the queue.
// ----------------------------------------------------------------------------
module sgi_front import sgi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  seg_in_t  item_i,
  output logic     full_o,
  output logic     job_push_o,
  output seg_job_t job_o,
  input  logic     job_full_i
);

  logic en;
  logic accept;

  // stage valids
  logic v1_q, v2_q, v3_q;

  // stage 1: edge and offset vectors
  diff_t  dax_q, day_q, dbx_q, dby_q, ox_q, oy_q;
  coord_t ax0_1_q, ay0_1_q;

  // stage 2: cross products
  prod_t  p_den_a_q, p_den_b_q, p_s_a_q, p_s_b_q, p_t_a_q, p_t_b_q;
  coord_t ax0_2_q, ay0_2_q;
  diff_t  dax_2_q, day_2_q;

  // stage 3: denominator and numerators
  sum_t   denom_q, s_num_q, t_num_q;
  coord_t ax0_3_q, ay0_3_q;
  diff_t  dax_3_q, day_3_q;

  // classification
  logic den_zero, pos, s_neg, t_neg, s_gt, t_gt, reject;

  function automatic diff_t coord_sub(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  // the whole front moves unless its last beat cannot enter the queue
  assign en     = !(v3_q && job_full_i);
  assign accept = push_i && en;
  assign full_o = !en;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      dax_q   <= coord_sub(item_i.a_end_x, item_i.a_start_x);
      day_q   <= coord_sub(item_i.a_end_y, item_i.a_start_y);
      dbx_q   <= coord_sub(item_i.b_end_x, item_i.b_start_x);
      dby_q   <= coord_sub(item_i.b_end_y, item_i.b_start_y);
      ox_q    <= coord_sub(item_i.a_start_x, item_i.b_start_x);
      oy_q    <= coord_sub(item_i.a_start_y, item_i.b_start_y);
      ax0_1_q <= item_i.a_start_x;
      ay0_1_q <= item_i.a_start_y;

      p_den_a_q <= prod_t'(dax_q) * prod_t'(dby_q);
      p_den_b_q <= prod_t'(dbx_q) * prod_t'(day_q);
      p_s_a_q   <= prod_t'(dax_q) * prod_t'(oy_q);
      p_s_b_q   <= prod_t'(day_q) * prod_t'(ox_q);
      p_t_a_q   <= prod_t'(dbx_q) * prod_t'(oy_q);
      p_t_b_q   <= prod_t'(dby_q) * prod_t'(ox_q);
      ax0_2_q   <= ax0_1_q;
      ay0_2_q   <= ay0_1_q;
      dax_2_q   <= dax_q;
      day_2_q   <= day_q;

      denom_q <= sum_t'(p_den_a_q) - sum_t'(p_den_b_q);
      s_num_q <= sum_t'(p_s_a_q) - sum_t'(p_s_b_q);
      t_num_q <= sum_t'(p_t_a_q) - sum_t'(p_t_b_q);
      ax0_3_q <= ax0_2_q;
      ay0_3_q <= ay0_2_q;
      dax_3_q <= dax_2_q;
      day_3_q <= day_2_q;
    end
  end

  // sign and range tests, kept asymmetric at the boundaries
  always_comb begin
    den_zero = (denom_q == '0);
    pos      = !denom_q[SUM_W-1] && !den_zero;
    s_neg    = s_num_q[SUM_W-1];
    t_neg    = t_num_q[SUM_W-1];
    s_gt     = s_num_q > denom_q;
    t_gt     = t_num_q > denom_q;
    reject   = den_zero || (s_neg == pos) || (t_neg == pos) ||
               (s_gt == pos) || (t_gt == pos);
  end

  // job beat into the queue
  always_comb begin
    job_o.hit   = !reject;
    job_o.t_mag = t_neg ? mag_t'(-t_num_q) : mag_t'(t_num_q);
    job_o.d_mag = denom_q[SUM_W-1] ? mag_t'(-denom_q) : mag_t'(denom_q);
    job_o.ax0   = ax0_3_q;
    job_o.ay0   = ay0_3_q;
    job_o.dax   = dax_3_q;
    job_o.day   = day_3_q;
  end

  assign job_push_o = v3_q && !job_full_i;

endmodule

// ===== hw/rtl/sgi_midq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_midq
// Short register queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module sgi_midq import sgi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  seg_job_t data_i,
  output logic     full_o,
  output logic     empty_o,
  input  logic     pop_i,
  output seg_job_t data_o
);

  seg_job_t               mem_q [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0]     wr_q, rd_q;
  logic [MIDQ_CW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == MIDQ_CW'(MIDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // occupancy
  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // a beat is never written into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("sgi_midq: push while full");

endmodule

// ===== hw/rtl/sgi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_back
// Back end: pipelined restoring divider for t, one quotient bit per stage,
// then the interpolation multiply, the final add and a two-entry result queue.
// ----------------------------------------------------------------------------
module sgi_back import sgi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_avail_i,
  input  seg_job_t job_i,
  output logic     job_pop_o,
  output logic     empty_o,
  input  logic     pop_i,
  output seg_out_t res_o
);

  localparam int    LERP_W   = QUOT_W + 1 + DIFF_W;
  localparam quot_t QUOT_ONE = quot_t'(1) << FRAC_T_BITS;

  typedef logic signed [LERP_W-1:0] lerp_t;

  typedef struct packed {
    logic   hit;
    mag_t   r;
    quot_t  q;
    mag_t   d;
    coord_t ax0;
    coord_t ay0;
    diff_t  dax;
    diff_t  day;
  } div_t;

  typedef struct packed {
    logic   hit;
    coord_t ax0;
    coord_t ay0;
    lerp_t  px;
    lerp_t  py;
  } mul_t;

  logic en;

  // divider stages
  div_t           div_q [FRAC_T_BITS+1];
  div_t           div_d [FRAC_T_BITS+1];
  logic           dv_q  [FRAC_T_BITS+1];
  logic [MAG_W:0] rem_sh [FRAC_T_BITS+1];
  logic           rem_ge [FRAC_T_BITS+1];

  // multiply stage
  mul_t mul_q, mul_d;
  logic mv_q;

  // result queue
  seg_out_t  oq_q [2];
  seg_out_t  res_d;
  logic      oq_wr_q, oq_rd_q;
  logic [1:0] oq_cnt_q;
  logic      oq_full, oq_push, oq_pop;

  // back pipeline moves unless its last beat cannot enter the result queue
  assign oq_full   = (oq_cnt_q == 2'd2);
  assign en        = !(mv_q && oq_full);
  assign job_pop_o = en && job_avail_i;
  assign oq_push   = mv_q && !oq_full;
  assign oq_pop    = pop_i && !empty_o;

  // restoring division: integer bit first, then one fraction bit per stage
  always_comb begin
    rem_sh[0]       = {1'b0, job_i.t_mag};
    rem_ge[0]       = job_i.t_mag >= job_i.d_mag;
    div_d[0].hit    = job_i.hit;
    div_d[0].r      = rem_ge[0] ? job_i.t_mag - job_i.d_mag : job_i.t_mag;
    div_d[0].q      = quot_t'(rem_ge[0]);
    div_d[0].d      = job_i.d_mag;
    div_d[0].ax0    = job_i.ax0;
    div_d[0].ay0    = job_i.ay0;
    div_d[0].dax    = job_i.dax;
    div_d[0].day    = job_i.day;
    for (int k = 1; k <= FRAC_T_BITS; k++) begin
      rem_sh[k]    = {div_q[k-1].r, 1'b0};
      rem_ge[k]    = rem_sh[k] >= {1'b0, div_q[k-1].d};
      div_d[k]     = div_q[k-1];
      div_d[k].r   = rem_ge[k] ? mag_t'(rem_sh[k] - {1'b0, div_q[k-1].d})
                               : mag_t'(rem_sh[k]);
      div_d[k].q   = {div_q[k-1].q[QUOT_W-2:0], rem_ge[k]};
    end
  end

  // t times edge vector of A
  always_comb begin
    mul_d.hit = div_q[FRAC_T_BITS].hit;
    mul_d.ax0 = div_q[FRAC_T_BITS].ax0;
    mul_d.ay0 = div_q[FRAC_T_BITS].ay0;
    mul_d.px  = lerp_t'({1'b0, div_q[FRAC_T_BITS].q}) * lerp_t'(div_q[FRAC_T_BITS].dax);
    mul_d.py  = lerp_t'({1'b0, div_q[FRAC_T_BITS].q}) * lerp_t'(div_q[FRAC_T_BITS].day);
  end

  // start plus shifted product, zero on a miss
  always_comb begin
    res_d.hit     = mul_q.hit;
    res_d.cross_x = '0;
    res_d.cross_y = '0;
    if (mul_q.hit) begin
      res_d.cross_x = mul_q.ax0 + coord_t'(mul_q.px[FRAC_T_BITS +: COORD_WIDTH]);
      res_d.cross_y = mul_q.ay0 + coord_t'(mul_q.py[FRAC_T_BITS +: COORD_WIDTH]);
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= FRAC_T_BITS; k++) dv_q[k] <= 1'b0;
      mv_q <= 1'b0;
    end else if (en) begin
      dv_q[0] <= job_pop_o;
      for (int k = 1; k <= FRAC_T_BITS; k++) dv_q[k] <= dv_q[k-1];
      mv_q <= dv_q[FRAC_T_BITS];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= FRAC_T_BITS; k++) div_q[k] <= div_d[k];
      mul_q <= mul_d;
    end
  end

  // result queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (oq_push) oq_wr_q <= !oq_wr_q;
      if (oq_pop)  oq_rd_q <= !oq_rd_q;
      case ({oq_push, oq_pop})
        2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
        2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
        default: oq_cnt_q <= oq_cnt_q;
      endcase
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (oq_push) oq_q[oq_wr_q] <= res_d;
  end

  assign empty_o = (oq_cnt_q == 2'd0);
  assign res_o   = oq_q[oq_rd_q];

  // result queue holds at most two beats
  assert property (@(posedge clk_i) disable iff (!rst_ni) oq_cnt_q != 2'd3)
    else $error("sgi_back: result queue overflow");

  // a hit leaves the divider with t in [0, 1]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[FRAC_T_BITS] && div_q[FRAC_T_BITS].hit |-> div_q[FRAC_T_BITS].q <= QUOT_ONE)
    else $error("sgi_back: quotient above one");

endmodule
